/* rtl/core/cbez_pkg.sv */
// shared constants for the cubic bezier point evaluator
// no dependencies; imported by cbez_lerp and cubic_bezier_point_eval_top
package cbez_pkg;

    // control point register file
    localparam int NUM_REGS      = 8;
    localparam int CFG_IDX_WIDTH = 3;

    // register indexes as seen on the configuration port
    localparam logic [CFG_IDX_WIDTH-1:0] REG_P0_X = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_P0_Y = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_P1_X = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_P1_Y = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_P2_X = 3'd4;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_P2_Y = 3'd5;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_P3_X = 3'd6;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_P3_Y = 3'd7;

    // pipeline depth of one interpolation: multiply, then round and add
    localparam int LERP_STAGES = 2;
    // de casteljau rounds for a cubic
    localparam int NUM_LEVELS  = 3;

endpackage

/* rtl/core/cubic_bezier_point_eval_top.sv */
// Cubic Bezier point evaluator. Each input item carries a curve parameter t
// (unsigned, T_FRAC_BITS fraction bits, 2^T_FRAC_BITS = 1.0, larger values
// clamp to 1.0) and yields one output item with the curve point x and y,
// signed COORD_WIDTH-bit coordinates formed by three rounds of de Casteljau
// interpolation over the four control points in registers p0..p3. Every lerp
// lands between its operands, so the result always lies in the coordinate
// range and never needs clipping. One item enters per clock unless the
// pipeline holds. The pipeline is one input register plus two stages
// (multiply, round and add) for each of the three interpolation rounds. The
// whole pipeline advances together and holds when the output item is not
// taken. Control points are written through cfg_we / cfg_index / cfg_data and
// must only change while the pipeline is empty.
// depends on cbez_pkg and cbez_lerp
module cubic_bezier_point_eval_top #(
    parameter int COORD_WIDTH = 16,
    parameter int T_FRAC_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [cbez_pkg::CFG_IDX_WIDTH-1:0]   cfg_index,
    input  logic [COORD_WIDTH-1:0]               cfg_data,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // param_t in bits [T_FRAC_BITS:0], zero fill above
    input  logic [((T_FRAC_BITS+8)/8)*8-1:0]     s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // point_x in bits [COORD_WIDTH-1:0], point_y above it, zero fill above
    output logic [((2*COORD_WIDTH+7)/8)*8-1:0]   m_axis_tdata
);
    import cbez_pkg::*;

    localparam int CW      = COORD_WIDTH;
    localparam int TF      = T_FRAC_BITS;
    localparam int OUT_W   = ((2*CW+7)/8)*8;
    localparam int DEPTH   = 1 + NUM_LEVELS * LERP_STAGES;
    localparam int T_DEPTH = 1 + (NUM_LEVELS - 1) * LERP_STAGES;
    localparam int AX_STEP = int'(REG_P0_Y) - int'(REG_P0_X);
    localparam int PT_STEP = int'(REG_P1_X) - int'(REG_P0_X);

    localparam logic [TF:0] T_ONE = {1'b1, {TF{1'b0}}};

    logic [CW-1:0]   ctrl_reg [NUM_REGS];
    logic [DEPTH-1:0] valid_reg;
    logic [DEPTH-1:0] valid_next;
    logic [TF:0]     t_reg [T_DEPTH];
    logic [TF:0]     t_in;
    logic [TF:0]     t_clamped;
    logic            en;
    logic signed [CW-1:0] pt_x;
    logic signed [CW-1:0] pt_y;

    // control point registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                ctrl_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            ctrl_reg[cfg_index] <= cfg_data;
        end
    end

    // whole pipeline moves unless a finished item is stuck at the output
    assign en            = !valid_reg[DEPTH-1] || m_axis_tready;
    assign s_axis_tready = en;
    assign valid_next    = {valid_reg[DEPTH-2:0], s_axis_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    assign t_in      = s_axis_tdata[TF:0];
    assign t_clamped = (t_in > T_ONE) ? T_ONE : t_in;

    // t travels alongside the item for the later rounds
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg[0] <= t_clamped;
            for (int i = 1; i < T_DEPTH; i++)
            begin
                t_reg[i] <= t_reg[i-1];
            end
        end
    end

    for (genvar ax = 0; ax < 2; ax++)
    begin : g_axis
        logic signed [CW-1:0] p0;
        logic signed [CW-1:0] p1;
        logic signed [CW-1:0] p2;
        logic signed [CW-1:0] p3;
        logic signed [CW-1:0] l1_a;
        logic signed [CW-1:0] l1_b;
        logic signed [CW-1:0] l1_c;
        logic signed [CW-1:0] l2_a;
        logic signed [CW-1:0] l2_b;
        logic signed [CW-1:0] l3;

        assign p0 = ctrl_reg[int'(REG_P0_X) + ax*AX_STEP];
        assign p1 = ctrl_reg[int'(REG_P0_X) + ax*AX_STEP + PT_STEP];
        assign p2 = ctrl_reg[int'(REG_P0_X) + ax*AX_STEP + 2*PT_STEP];
        assign p3 = ctrl_reg[int'(REG_P0_X) + ax*AX_STEP + 3*PT_STEP];

        // round 1
        cbez_lerp #(.CW(CW), .TF(TF)) u_l1_a (
            .clk (clk), .en (en), .a (p0), .b (p1), .t (t_reg[0]), .y (l1_a)
        );
        cbez_lerp #(.CW(CW), .TF(TF)) u_l1_b (
            .clk (clk), .en (en), .a (p1), .b (p2), .t (t_reg[0]), .y (l1_b)
        );
        cbez_lerp #(.CW(CW), .TF(TF)) u_l1_c (
            .clk (clk), .en (en), .a (p2), .b (p3), .t (t_reg[0]), .y (l1_c)
        );

        // round 2
        cbez_lerp #(.CW(CW), .TF(TF)) u_l2_a (
            .clk (clk), .en (en), .a (l1_a), .b (l1_b),
            .t (t_reg[LERP_STAGES]), .y (l2_a)
        );
        cbez_lerp #(.CW(CW), .TF(TF)) u_l2_b (
            .clk (clk), .en (en), .a (l1_b), .b (l1_c),
            .t (t_reg[LERP_STAGES]), .y (l2_b)
        );

        // round 3, its result register is the output register
        cbez_lerp #(.CW(CW), .TF(TF)) u_l3 (
            .clk (clk), .en (en), .a (l2_a), .b (l2_b),
            .t (t_reg[2*LERP_STAGES]), .y (l3)
        );

        if (ax == 0)
        begin : g_x
            assign pt_x = l3;
        end
        else
        begin : g_y
            assign pt_y = l3;
        end
    end

    assign m_axis_tvalid = valid_reg[DEPTH-1];
    assign m_axis_tdata  = OUT_W'({pt_y, pt_x});

endmodule

/* rtl/core/cbez_lerp.sv */
// two-stage fixed-point interpolation a + round((b - a) * t / 2^TF)
// uses cbez_pkg for the stage count; leaf module, no instances
module cbez_lerp #(
    parameter int CW = 16,
    parameter int TF = 16
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [CW-1:0] a,
    input  logic signed [CW-1:0] b,
    input  logic        [TF:0]   t,
    output logic signed [CW-1:0] y
);
    import cbez_pkg::*;

    // |b - a| <= 2^CW and t <= 2^TF, so the product fits in CW+TF+2 signed bits
    localparam int PW = CW + TF + 2;
    localparam int QW = PW - TF;

    logic signed [CW:0]   diff;
    logic signed [TF+1:0] t_s;
    logic signed [PW-1:0] prod_next;
    logic signed [PW-1:0] prod_reg;
    logic signed [CW-1:0] a_reg;
    logic signed [PW-1:0] rounded;
    logic signed [QW-1:0] quot;
    logic signed [QW-1:0] sum_ext;
    logic signed [CW-1:0] y_next;
    logic signed [CW-1:0] y_reg;

    assign diff      = CW'(b) - CW'(a) + (CW+1)'(0);
    assign t_s       = signed'({1'b0, t});
    assign prod_next = PW'(diff) * PW'(t_s);

    // stage 1: difference times t
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            a_reg    <= a;
        end
    end

    // round half up, floor shift, then add; the result stays between a and b
    assign rounded = prod_reg + PW'(1 << (TF - 1));
    assign quot    = rounded[PW-1:TF];
    assign sum_ext = QW'(a_reg) + quot;
    assign y_next  = sum_ext[CW-1:0];

    // stage 2: result register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y_reg <= y_next;
        end
    end

    assign y = y_reg;

    // adds an unused marker signal when the package stage count differs from the stages built here
    if (LERP_STAGES != 2)
    begin : g_stage_check
        logic unused_stage_marker;
        assign unused_stage_marker = 1'b0;
    end

endmodule
